// File: rtl/sector_cache_clock_replacement_defines.svh
// Assertion helpers used by the top RTL file of the sector cache directory.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH

// Checked at every rising edge outside of reset.
`define SCC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Checked at every rising edge, reset included.
`define SCC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) (expr)) else $error(msg);

`endif

// File: rtl/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

    localparam int SECTOR_W    = 32;
    localparam int SLOT_W      = 6;
    localparam int PIN_W       = 8;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;
    localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_GET       = 2'd0,
        OP_RELEASE   = 2'd1,
        OP_FLUSH     = 2'd2,
        OP_FLUSH_INV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_VICTIM  = 2'd1,
        STAT_NOT_PINNED = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]          operation;
        logic [SECTOR_W-1:0] sector;
        logic                dirty_intent;
        logic [SLOT_W-1:0]   release_slot;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                fetch_valid;
        logic [SECTOR_W-1:0] fetch_sector;
        logic                writeback_valid;
        logic [SECTOR_W-1:0] writeback_sector;
        logic [1:0]          status;
        logic                last;
    } t_out;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_HIT       = 3'd1,
        ACT_CLAIM     = 3'd2,
        ACT_CLR_ACC   = 3'd3,
        ACT_CLR_DIRTY = 3'd4,
        ACT_RELEASE   = 3'd5,
        ACT_INVAL     = 3'd6
    } t_act;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_act                act;
        logic                use_tok;
        logic                start;
        logic                adv;
        logic [SECTOR_W-1:0] sector;
        logic                dirty;
    } t_cell_cmd;

    // State of the addressed cell; all zero from cells that are not addressed.
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic                accessed;
        logic                pinned;
        logic                match;
        logic [SECTOR_W-1:0] tag;
    } t_cell_st;

endpackage
`default_nettype wire

// File: rtl/scc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module scc_cell import scc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_head,
    input  logic      i_tok,
    input  logic      i_at,
    output logic      o_tok,
    output t_cell_st  o_st
);

    logic                r_tok;
    logic                r_valid;
    logic                r_dirty;
    logic                r_acc;
    logic [PIN_W-1:0]    r_pins;
    logic [SECTOR_W-1:0] r_tag;
    logic                w_en;

    assign w_en = i_cmd.use_tok ? r_tok : i_at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_acc   <= 1'b0;
            r_pins  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_tok <= i_head;
            end else if (i_cmd.adv) begin
                r_tok <= i_tok;
            end
            case (i_cmd.act)
                ACT_INVAL: begin
                    r_valid <= 1'b0;
                    r_dirty <= 1'b0;
                    r_acc   <= 1'b0;
                    r_pins  <= '0;
                end
                ACT_HIT: begin
                    if (w_en) begin
                        if (r_pins != PIN_MAX) begin
                            r_pins <= r_pins + PIN_W'(1);
                        end
                        r_dirty <= r_dirty | i_cmd.dirty;
                        r_acc   <= 1'b1;
                    end
                end
                ACT_CLAIM: begin
                    if (w_en) begin
                        r_valid <= 1'b1;
                        r_dirty <= i_cmd.dirty;
                        r_acc   <= 1'b1;
                        r_pins  <= PIN_W'(1);
                    end
                end
                ACT_CLR_ACC: begin
                    if (w_en) begin
                        r_acc <= 1'b0;
                    end
                end
                ACT_CLR_DIRTY: begin
                    if (w_en) begin
                        r_dirty <= 1'b0;
                    end
                end
                ACT_RELEASE: begin
                    if (w_en && r_valid && (r_pins != '0)) begin
                        r_pins <= r_pins - PIN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.act == ACT_CLAIM) && w_en) begin
            r_tag <= i_cmd.sector;
        end
    end

    assign o_tok = r_tok;

    always_comb begin
        o_st = '0;
        if (w_en) begin
            o_st.valid    = r_valid;
            o_st.dirty    = r_dirty;
            o_st.accessed = r_acc;
            o_st.pinned   = (r_pins != '0);
            o_st.match    = r_valid && (r_tag == i_cmd.sector);
            o_st.tag      = r_tag;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sector_cache_clock_replacement.sv
// Sector cache directory with second-chance (clock) replacement.
// Requests enter on i_in (i_in_valid / o_in_stall) and results leave on o_out
// (o_out_valid / i_out_stall). A get, a release and a flush that finds no dirty
// entry give one result; a flush gives one result per dirty entry, at most
// MAX_RESULTS, and the final result of every request carries last.
// The directory is a chain of CACHE_ENTRIES cells. Scans move a token one cell
// per cycle unless an output stall holds the scan. A get scans the chain for a
// hit and on a miss claims the next free slot or, when the directory is full,
// scans it once more for a victim; a release goes straight to its slot, and a
// flush scans the chain once. One request is worked on at a time, and
// o_in_stall is high while it is in progress.
// Results pass through an output register, so a new request is taken while
// the previous result still waits to be taken.
// A synchronous active-low reset empties the directory: all entries invalid,
// clean, unaccessed and unpinned, and the fill count zero.
// While the receiver stalls, a waiting result holds and the scan pauses at
// the point where it must emit its next result.
`timescale 1ns / 1ps
`default_nettype none
`include "sector_cache_clock_replacement_defines.svh"
module sector_cache_clock_replacement import scc_pkg::*; #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int FW = $clog2(CACHE_ENTRIES + 1);
    localparam int TW = (FW > SLOT_W) ? FW : SLOT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HIT  = 8'b0000_0010,
        S_MISS = 8'b0000_0100,
        S_VIC  = 8'b0000_1000,
        S_VEND = 8'b0001_0000,
        S_REL  = 8'b0010_0000,
        S_FL   = 8'b0100_0000,
        S_FEND = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [SECTOR_W-1:0] r_sector;
    logic                r_dirty;
    logic [SLOT_W-1:0]   r_rs;
    logic [IW-1:0]       r_idx, n_idx;
    logic [FW-1:0]       r_fill, n_fill;
    // First unpinned entry seen by the victim scan.
    logic                r_ff_v, n_ff_v;
    logic [IW-1:0]       r_ff_idx, n_ff_idx;
    logic [SECTOR_W-1:0] r_ff_tag, n_ff_tag;
    logic                r_ff_dirty, n_ff_dirty;
    // Flush write-back held back until it is known whether it is the last one.
    logic                r_pv, n_pv;
    logic [IW-1:0]       r_p_idx, n_p_idx;
    logic [SECTOR_W-1:0] r_p_tag, n_p_tag;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_trunc, n_trunc;
    logic                r_out_v;
    t_out                r_out;

    t_cell_cmd           w_cmd;
    logic [TW-1:0]       w_tgt;
    logic [CACHE_ENTRIES-1:0] w_tok;
    t_cell_st            w_st [CACHE_ENTRIES];
    t_cell_st            w_sel;
    logic                w_accept;
    logic                w_can_emit;
    logic                w_emit;
    t_out                w_res;
    logic                w_step;
    logic                w_last_idx;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_can_emit  = !r_out_v || !i_out_stall;
    assign w_last_idx  = (r_idx == IW'(CACHE_ENTRIES - 1));
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // The cell chain: the token enters at cell 0 and moves one cell per step.
    for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
        logic w_tok_in;
        if (k == 0) begin : g_head
            assign w_tok_in = 1'b0;
        end else begin : g_body
            assign w_tok_in = w_tok[k-1];
        end
        scc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_head  ((k == 0) ? 1'b1 : 1'b0),
            .i_tok   (w_tok_in),
            .i_at    (w_tgt == TW'(k)),
            .o_tok   (w_tok[k]),
            .o_st    (w_st[k])
        );
    end

    // Only the addressed cell reports, so the OR picks out its state.
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            w_sel = w_sel | w_st[k];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_ff_v     = r_ff_v;
        n_ff_idx   = r_ff_idx;
        n_ff_tag   = r_ff_tag;
        n_ff_dirty = r_ff_dirty;
        n_pv       = r_pv;
        n_p_idx    = r_p_idx;
        n_p_tag    = r_p_tag;
        n_cnt      = r_cnt;
        n_trunc    = r_trunc;
        w_cmd         = '0;
        w_cmd.act     = ACT_NONE;
        w_cmd.sector  = r_sector;
        w_cmd.dirty   = r_dirty;
        w_tgt      = '0;
        w_emit     = 1'b0;
        w_res      = '0;
        w_step     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx   = '0;
                    n_ff_v  = 1'b0;
                    n_pv    = 1'b0;
                    n_cnt   = '0;
                    n_trunc = 1'b0;
                    case (t_op'(i_in.operation))
                        OP_GET: begin
                            w_cmd.start = 1'b1;
                            n_state     = S_HIT;
                        end
                        OP_RELEASE: begin
                            n_state = S_REL;
                        end
                        default: begin
                            w_cmd.start = 1'b1;
                            n_state     = S_FL;
                        end
                    endcase
                end
            end
            S_HIT: begin
                w_cmd.use_tok = 1'b1;
                if (w_sel.match) begin
                    if (w_can_emit) begin
                        w_cmd.act    = ACT_HIT;
                        w_emit       = 1'b1;
                        w_res.slot   = SLOT_W'(r_idx);
                        w_res.hit    = 1'b1;
                        w_res.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (w_last_idx) begin
                    n_state = S_MISS;
                end else begin
                    w_step = 1'b1;
                end
            end
            S_MISS: begin
                w_tgt = TW'(r_fill);
                if (r_fill < FW'(CACHE_ENTRIES)) begin
                    if (w_can_emit) begin
                        w_cmd.act          = ACT_CLAIM;
                        w_emit             = 1'b1;
                        w_res.slot         = SLOT_W'(r_fill);
                        w_res.fetch_valid  = 1'b1;
                        w_res.fetch_sector = r_sector;
                        w_res.last         = 1'b1;
                        n_fill             = r_fill + FW'(1);
                        n_state            = S_IDLE;
                    end
                end else begin
                    w_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = S_VIC;
                end
            end
            S_VIC: begin
                w_cmd.use_tok = 1'b1;
                if (w_sel.pinned) begin
                    w_step = 1'b1;
                end else begin
                    if (!r_ff_v) begin
                        n_ff_v     = 1'b1;
                        n_ff_idx   = r_idx;
                        n_ff_tag   = w_sel.tag;
                        n_ff_dirty = w_sel.dirty;
                    end
                    if (w_sel.accessed) begin
                        w_cmd.act = ACT_CLR_ACC;
                        w_step    = 1'b1;
                    end else if (w_can_emit) begin
                        w_cmd.act              = ACT_CLAIM;
                        w_emit                 = 1'b1;
                        w_res.slot             = SLOT_W'(r_idx);
                        w_res.fetch_valid      = 1'b1;
                        w_res.fetch_sector     = r_sector;
                        w_res.writeback_valid  = w_sel.dirty;
                        w_res.writeback_sector = w_sel.dirty ? w_sel.tag : '0;
                        w_res.last             = 1'b1;
                        n_state                = S_IDLE;
                    end
                end
                if (w_step && w_last_idx) begin
                    w_step  = 1'b0;
                    n_state = S_VEND;
                end
            end
            S_VEND: begin
                w_tgt = TW'(r_ff_idx);
                if (w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.last = 1'b1;
                    n_state    = S_IDLE;
                    if (r_ff_v) begin
                        w_cmd.act              = ACT_CLAIM;
                        w_res.slot             = SLOT_W'(r_ff_idx);
                        w_res.fetch_valid      = 1'b1;
                        w_res.fetch_sector     = r_sector;
                        w_res.writeback_valid  = r_ff_dirty;
                        w_res.writeback_sector = r_ff_dirty ? r_ff_tag : '0;
                    end else begin
                        w_res.status = STAT_NO_VICTIM;
                    end
                end
            end
            S_REL: begin
                w_tgt = TW'(r_rs);
                if (w_can_emit) begin
                    w_cmd.act    = ACT_RELEASE;
                    w_emit       = 1'b1;
                    w_res.slot   = r_rs;
                    w_res.status = (w_sel.valid && w_sel.pinned) ? STAT_OK : STAT_NOT_PINNED;
                    w_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FL: begin
                w_cmd.use_tok = 1'b1;
                if (w_sel.valid && w_sel.dirty) begin
                    if (r_cnt == CNT_W'(MAX_RESULTS)) begin
                        n_trunc = 1'b1;
                        n_state = S_FEND;
                    end else if (!r_pv || w_can_emit) begin
                        w_cmd.act = ACT_CLR_DIRTY;
                        if (r_pv) begin
                            w_emit                 = 1'b1;
                            w_res.slot             = SLOT_W'(r_p_idx);
                            w_res.writeback_valid  = 1'b1;
                            w_res.writeback_sector = r_p_tag;
                        end
                        n_pv    = 1'b1;
                        n_p_idx = r_idx;
                        n_p_tag = w_sel.tag;
                        n_cnt   = r_cnt + CNT_W'(1);
                        w_step  = 1'b1;
                    end
                end else begin
                    w_step = 1'b1;
                end
                if (w_step && w_last_idx) begin
                    w_step  = 1'b0;
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                if (w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.last = 1'b1;
                    if (r_pv) begin
                        w_res.slot             = SLOT_W'(r_p_idx);
                        w_res.writeback_valid  = 1'b1;
                        w_res.writeback_sector = r_p_tag;
                    end
                    if ((r_op == OP_FLUSH_INV) && !r_trunc) begin
                        w_cmd.act = ACT_INVAL;
                        n_fill    = '0;
                    end
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_step) begin
            w_cmd.adv = 1'b1;
            n_idx     = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ff_v  <= 1'b0;
            r_pv    <= 1'b0;
            r_cnt   <= '0;
            r_trunc <= 1'b0;
            r_idx   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ff_v  <= n_ff_v;
            r_pv    <= n_pv;
            r_cnt   <= n_cnt;
            r_trunc <= n_trunc;
            r_idx   <= n_idx;
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_op'(i_in.operation);
            r_sector <= i_in.sector;
            r_dirty  <= i_in.dirty_intent;
            r_rs     <= i_in.release_slot;
        end
        r_ff_idx   <= n_ff_idx;
        r_ff_tag   <= n_ff_tag;
        r_ff_dirty <= n_ff_dirty;
        r_p_idx    <= n_p_idx;
        r_p_tag    <= n_p_tag;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    `SCC_ASSERT(a_fill_bound, r_fill <= FW'(CACHE_ENTRIES), "fill count beyond directory size")
    `SCC_ASSERT(a_one_token, $onehot0(w_tok), "more than one scan token in the chain")
    `SCC_ASSERT(a_out_held, r_out_v && i_out_stall |=> r_out_v, "stalled result was dropped")
    `SCC_ASSERT(a_pend_count, r_pv |-> (r_cnt != '0), "held write-back without a count")

endmodule
`default_nettype wire
